>>> sv/rvmt_pkg.sv
`timescale 1ns / 1ps
package rvmt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int REG_W     = 64;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIM       = 4;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef q_t    [DIM-1:0][DIM-1:0] mat_t;
    typedef prod_t [DIM-1:0][DIM-1:0] prods_t;
    typedef pair_t [DIM-1:0][1:0]     pairs_t;
    typedef sum_t  [DIM-1:0]          sums_t;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

    typedef struct packed {
        q_t vec_x;
        q_t vec_y;
        q_t vec_z;
        q_t vec_w;
    } vec_in_t;

    typedef struct packed {
        q_t   res_x;
        q_t   res_y;
        q_t   res_z;
        q_t   res_w;
        logic saturated;
    } vec_out_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HI = ONE_LO << Q_W;

    // identity: rows 0..3, index 2*row + column pair
    localparam cfg_regs_t CFG_RESET = {
        ONE_HI, {REG_W{1'b0}},
        ONE_LO, {REG_W{1'b0}},
        {REG_W{1'b0}}, ONE_HI,
        {REG_W{1'b0}}, ONE_LO
    };

endpackage

>>> sv/rvmt_cfg.sv
`timescale 1ns / 1ps
module rvmt_cfg
    import rvmt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_wdata,
    output mat_t             mat
);

    cfg_regs_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                mat[r][c] = q_t'(cfg_reg[2*r + c/2][Q_W*(c%2) +: Q_W]);
            end
        end
    end

    a_reset_identity: assert property (@(posedge aclk)
        !aresetn |=> cfg_reg == CFG_RESET)
        else $error("matrix not identity after reset");

endmodule

>>> sv/rvmt_mul.sv
`timescale 1ns / 1ps
module rvmt_mul
    import rvmt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  vec_in_t in_data,
    input  mat_t    mat,
    output logic    out_valid,
    input  logic    out_ready,
    output prods_t  out_prod
);

    logic   valid_reg;
    prods_t prod_reg;
    prods_t prod_next;
    q_t     v [DIM];

    assign v[0] = in_data.vec_x;
    assign v[1] = in_data.vec_y;
    assign v[2] = in_data.vec_z;
    assign v[3] = in_data.vec_w;

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                prod_next[r][c] = prod_t'(v[r]) * prod_t'(mat[r][c]);
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

>>> sv/rvmt_sum.sv
`timescale 1ns / 1ps
module rvmt_sum
    import rvmt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  prods_t in_prod,
    output logic   out_valid,
    input  logic   out_ready,
    output sums_t  out_sum
);

    logic   pair_valid_reg;
    logic   sum_valid_reg;
    logic   pair_ready;
    pairs_t pair_reg;
    pairs_t pair_next;
    sums_t  sum_reg;
    sums_t  sum_next;

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            pair_next[c][0] = pair_t'(in_prod[0][c]) + pair_t'(in_prod[1][c]);
            pair_next[c][1] = pair_t'(in_prod[2][c]) + pair_t'(in_prod[3][c]);
            sum_next[c]     = sum_t'(pair_reg[c][0]) + sum_t'(pair_reg[c][1]);
        end
    end

    assign pair_ready = !sum_valid_reg || out_ready;
    assign in_ready   = !pair_valid_reg || pair_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                pair_valid_reg <= in_valid;
            end
            if (pair_ready) begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pair_reg <= pair_next;
        end
        if (pair_ready && pair_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

>>> sv/rvmt_sat.sv
`timescale 1ns / 1ps
module rvmt_sat
    import rvmt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sums_t    in_sum,
    output logic     out_valid,
    input  logic     out_ready,
    output vec_out_t out_data
);

    logic           valid_reg;
    vec_out_t       data_reg;
    vec_out_t       data_next;
    q_t             res  [DIM];
    logic [DIM-1:0] clip;
    sum_t           shifted [DIM];

    always_comb begin
        for (int c = 0; c < DIM; c++) begin
            shifted[c] = in_sum[c] >>> FRAC_BITS;
            clip[c]    = !((&shifted[c][SUM_W-1:Q_W-1]) || !(|shifted[c][SUM_W-1:Q_W-1]));
            if (!clip[c]) begin
                res[c] = q_t'(shifted[c][Q_W-1:0]);
            end else if (shifted[c][SUM_W-1]) begin
                res[c] = Q_MIN;
            end else begin
                res[c] = Q_MAX;
            end
        end
        data_next.res_x     = res[0];
        data_next.res_y     = res[1];
        data_next.res_z     = res[2];
        data_next.res_w     = res[3];
        data_next.saturated = |clip;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/row_vector_matrix_transform_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  vec_in_t  (vec_x, vec_y, vec_z, vec_w)
// m_        out        m_valid / m_ready  vec_out_t (res_x..res_w, saturated)
// cfg_      in         cfg_we             cfg_index, cfg_wdata (matrix rows)
//
// One transfer per cycle sustained while m_ready stays high; register stages
// multiply, pair add, column add and shift/saturate, each with its own valid.
// Synchronous active-low reset clears all valids and loads the identity.
// A stall at m_ holds the pipeline; empty stages still take new transfers.
module row_vector_matrix_transform_top
    import rvmt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  vec_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output vec_out_t         m_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_wdata
);

    mat_t   mat;
    logic   mul_valid;
    logic   mul_ready;
    prods_t mul_prod;
    logic   sum_valid;
    logic   sum_ready;
    sums_t  sum_data;

    rvmt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .mat       (mat)
    );

    rvmt_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .mat       (mat),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_prod  (mul_prod)
    );

    rvmt_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_prod   (mul_prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum_data)
    );

    rvmt_sat u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.res_x == Q_MAX || m_data.res_x == Q_MIN ||
             m_data.res_y == Q_MAX || m_data.res_y == Q_MIN ||
             m_data.res_z == Q_MAX || m_data.res_z == Q_MIN ||
             m_data.res_w == Q_MAX || m_data.res_w == Q_MIN))
        else $error("saturated flag without a clamped component");

endmodule

>>> bench/row_vector_matrix_transform_top_tb.sv
`timescale 1ns / 1ps
module row_vector_matrix_transform_top_tb;
    import rvmt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 50;

    typedef enum {MX_IDENTITY, MX_ALL_MAX, MX_ALL_MIN, MX_HALF, MX_ZERO} mx_sel_t;

    typedef struct {
        mx_sel_t  mx;
        vec_in_t  vec;
        bit       typed;
        vec_out_t res;
    } vec_case_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    vec_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    vec_out_t         m_data;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_wdata = '0;

    cfg_regs_t cfg_shadow = CFG_RESET;
    vec_out_t  expected_q [$];
    int        fail_cnt       = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    bit        use_typed      = 1'b0;
    vec_out_t  typed_res      = '0;
    mx_sel_t   cur_mx         = MX_IDENTITY;

    vec_case_t directed_cases [15] = '{
        '{MX_IDENTITY, '{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0}},
        '{MX_IDENTITY, '{Q_MAX, Q_MIN, 1, -1}, 1'b1, '{Q_MAX, Q_MIN, 1, -1, 1'b0}},
        '{MX_IDENTITY, '{Q_MIN, Q_MAX, -1, 1}, 1'b1, '{Q_MIN, Q_MAX, -1, 1, 1'b0}},
        '{MX_IDENTITY, '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh1234_5678},
          1'b1, '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh1234_5678, 1'b0}},
        '{MX_ALL_MAX, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1}},
        '{MX_ALL_MAX, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1}},
        '{MX_ALL_MAX, '{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b0}},
        '{MX_ALL_MAX, '{1, 0, 0, 0}, 1'b0, '0},
        '{MX_ALL_MAX, '{Q_MAX, Q_MIN, 0, 0}, 1'b0, '0},
        '{MX_ALL_MIN, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1}},
        '{MX_ALL_MIN, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b1, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1}},
        '{MX_ALL_MIN, '{-1, 0, 0, 0}, 1'b0, '0},
        // half on the diagonal: odd products round towards minus infinity
        '{MX_HALF, '{1, -1, 3, -3}, 1'b0, '0},
        '{MX_HALF, '{Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 1'b0, '0},
        '{MX_ZERO, '{Q_MAX, Q_MIN, -1, 32'sh7654_3210}, 1'b1, '{0, 0, 0, 0, 1'b0}}
    };

    row_vector_matrix_transform_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic vec_out_t transform_row(vec_in_t v);
        q_t                  comp  [DIM];
        q_t                  lanes [DIM];
        q_t                  elem;
        logic signed [127:0] acc;
        logic                clip;
        comp[0] = v.vec_x;
        comp[1] = v.vec_y;
        comp[2] = v.vec_z;
        comp[3] = v.vec_w;
        clip = 1'b0;
        for (int c = 0; c < DIM; c++) begin
            acc = '0;
            for (int r = 0; r < DIM; r++) begin
                elem = cfg_shadow[2 * r + c / 2][Q_W * (c % 2) +: Q_W];
                acc = acc + comp[r] * elem;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > Q_MAX) begin
                lanes[c] = Q_MAX;
                clip = 1'b1;
            end else if (acc < Q_MIN) begin
                lanes[c] = Q_MIN;
                clip = 1'b1;
            end else begin
                lanes[c] = acc[Q_W-1:0];
            end
        end
        return '{lanes[0], lanes[1], lanes[2], lanes[3], clip};
    endfunction

    function automatic cfg_regs_t diag_matrix(q_t d);
        cfg_regs_t regs;
        regs = '0;
        for (int r = 0; r < DIM; r++)
            regs[2 * r + r / 2][Q_W * (r % 2) +: Q_W] = d;
        return regs;
    endfunction

    function automatic cfg_regs_t fill_matrix(q_t e);
        cfg_regs_t regs;
        for (int i = 0; i < NUM_REGS; i++)
            regs[i] = {e, e};
        return regs;
    endfunction

    function automatic cfg_regs_t matrix_for(mx_sel_t sel);
        case (sel)
            MX_ALL_MAX: return fill_matrix(Q_MAX);
            MX_ALL_MIN: return fill_matrix(Q_MIN);
            MX_HALF:    return diag_matrix(32'sh0000_8000);
            MX_ZERO:    return fill_matrix(0);
            default:    return diag_matrix(32'sh0001_0000);
        endcase
    endfunction

    function automatic q_t extreme_q();
        case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 0;
            3:       return -1;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    function automatic q_t rand_component();
        case ($urandom_range(0, 7))
            0, 1:    return q_t'($urandom);
            2:       return extreme_q();
            default: return q_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // tame entries lie in +/-4.0 bar one in eight extremes; most sums unclipped
    function automatic cfg_regs_t rand_matrix(bit tame);
        cfg_regs_t regs;
        q_t        e;
        for (int i = 0; i < NUM_REGS; i++) begin
            for (int h = 0; h < 2; h++) begin
                if (!tame)
                    e = q_t'($urandom);
                else if ($urandom_range(0, 7) == 0)
                    e = extreme_q();
                else
                    e = q_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                regs[i][Q_W * h +: Q_W] = e;
            end
        end
        return regs;
    endfunction

    task automatic load_matrix(cfg_regs_t regs);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we        = 1'b1;
            cfg_index     = IDX_W'(i);
            cfg_wdata     = regs[i];
            cfg_shadow[i] = regs[i];
            @(negedge aclk);
        end
        cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic send_vec(vec_in_t v, bit typed, vec_out_t res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        use_typed = typed;
        typed_res = res;
        s_data    = v;
        s_valid   = 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready = ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin : check_results
        vec_out_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected result %h", m_data);
                    fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_data.res_x !== e.res_x || m_data.res_y !== e.res_y ||
                        m_data.res_z !== e.res_z || m_data.res_w !== e.res_w ||
                        m_data.saturated !== e.saturated) begin
                        if (fail_cnt < 10)
                            $display("mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                                     e.res_x, e.res_y, e.res_z, e.res_w, e.saturated,
                                     m_data.res_x, m_data.res_y, m_data.res_z, m_data.res_w,
                                     m_data.saturated);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(use_typed ? typed_res : transform_row(s_data));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        send_idle_pct  = 32;
        recv_stall_pct = 64;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_cases[i]) begin
            if (directed_cases[i].mx != cur_mx) begin
                drain_results();
                load_matrix(matrix_for(directed_cases[i].mx));
                cur_mx = directed_cases[i].mx;
            end
            send_vec(directed_cases[i].vec, directed_cases[i].typed, directed_cases[i].res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            send_idle_pct  = (ph < 4) ? 32 : (ph < 8) ? 64 : 0;
            recv_stall_pct = (ph < 4) ? 64 : (ph < 8) ? 32 : 0;
            drain_results();
            load_matrix(rand_matrix(ph % 3 != 0));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && ph % 2 == 0)
                    drain_results();
                send_vec('{rand_component(), rand_component(), rand_component(),
                           rand_component()}, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(negedge aclk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rvmt_pkg.sv
sv/rvmt_cfg.sv
sv/rvmt_mul.sv
sv/rvmt_sum.sv
sv/rvmt_sat.sv
sv/row_vector_matrix_transform_top.sv
bench/row_vector_matrix_transform_top_tb.sv
